// ----- hdl/graph_bfs_dfs_traversal_unit_assert.svh -----
// Assertion macros used by the traversal sequencer (gbt_seq).
`ifndef GRAPH_BFS_DFS_TRAVERSAL_UNIT_ASSERT_SVH
`define GRAPH_BFS_DFS_TRAVERSAL_UNIT_ASSERT_SVH

// Implication checked every cycle outside reset.
`define GBT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define GBT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/gbt_pkg.sv -----
package gbt_pkg;

  // Vertex ports are 5 bits wide, so the vertex count is fixed here.
  localparam int MAX_VERTICES = 32;

  localparam logic [1:0] REQ_EDGE = 2'd0;
  localparam logic [1:0] REQ_BFS  = 2'd1;
  localparam logic [1:0] REQ_DFS  = 2'd2;

  localparam logic [1:0] ST_VISIT  = 2'd0;
  localparam logic [1:0] ST_STORED = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EDGE  = 7'b0000010,
    S_POP   = 7'b0000100,
    S_FETCH = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_CLEAR = 7'b1000000
  } state_t;

  // Result beat from the sequencer.
  typedef struct packed {
    logic       vld;
    logic [4:0] vtx;
    logic [1:0] status;
    logic       last;
  } beat_t;

endpackage

// ----- hdl/gbt_adj_mem.sv -----
module gbt_adj_mem import gbt_pkg::*; #(
  parameter int AW = 8,
  parameter int DW = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/gbt_seq.sv -----
module gbt_seq import gbt_pkg::*; #(
  parameter int MAX_DEGREE   = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] req_type,
  input  logic [4:0] vertex_a,
  input  logic [4:0] vertex_b,
  input  logic [5:0] num_vertices,
  output logic       busy,
  output beat_t      beat
);

  `include "graph_bfs_dfs_traversal_unit_assert.svh"

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int AW = VW + IW;
  localparam int PW = $clog2(MAX_VERTICES + 1);

  state_t state_r, state_nxt;

  logic [DW-1:0] cnt_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] vis_r;
  logic [VW-1:0] q_r [MAX_VERTICES];
  logic [VW-1:0] sv_r [MAX_VERTICES];
  logic [DW-1:0] si_r [MAX_VERTICES];

  logic [1:0] req_r;
  logic [VW-1:0] a_r, b_r, top_r;
  logic [PW-1:0] head_r, tail_r, sp_r;
  logic [DW-1:0] idx_r, tcnt_r;
  logic [6:0] nlim_r;
  logic       edge_phase_r;
  logic       pend_r;
  logic [VW-1:0] pend_v_r;
  beat_t beat_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [VW-1:0] wdata, rdata;

  gbt_adj_mem #(.AW(AW), .DW(VW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // 7-bit sign-free compare against the active count.
  function automatic logic in_rng(input logic [6:0] v, input logic [6:0] n);
    in_rng = v < n;
  endfunction

  logic [6:0] nact;
  logic [6:0] a_ext, b_ext, nb_ext;
  logic       a_ok, b_ok, nb_ok;

  always_comb begin
    nact = (7'(num_vertices) > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : 7'(num_vertices);
    a_ext = 7'(vertex_a);
    b_ext = 7'(vertex_b);
    a_ok = in_rng(a_ext, nact) && (a_ext < 7'(MAX_VERTICES));
    b_ok = in_rng(b_ext, nact) && (b_ext < 7'(MAX_VERTICES));
    nb_ext = 7'(rdata);
    nb_ok = in_rng(nb_ext, nlim_r);
  end

  assign busy = (state_r != S_IDLE);
  assign beat = beat_r;

  // Memory port: write for edges, read for scans.
  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    if (state_r == S_EDGE) begin
      we = 1'b1;
      if (!edge_phase_r) begin
        waddr = {a_r, cnt_r[a_r][IW-1:0]};
        wdata = b_r;
      end else begin
        waddr = {b_r, cnt_r[b_r][IW-1:0]};
        wdata = a_r;
      end
    end
    raddr = {top_r, idx_r[IW-1:0]};
  end

  logic emit_nb;
  assign emit_nb = (state_r == S_SCAN) && nb_ok && !vis_r[rdata] &&
                   (req_r == REQ_BFS ? (tail_r < PW'(MAX_VERTICES)) :
                                       (sp_r < PW'(MAX_VERTICES)));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) begin
        if (req_type == REQ_EDGE) state_nxt = (a_ok && b_ok) ? S_EDGE : S_IDLE;
        else if ((req_type == REQ_BFS || req_type == REQ_DFS) && a_ok) state_nxt = S_POP;
      end
      S_EDGE:  if (edge_phase_r) state_nxt = S_IDLE;
      S_POP:   state_nxt = S_FETCH;
      S_FETCH: state_nxt = (idx_r < tcnt_r) ? S_SCAN : S_POP;
      S_SCAN:  state_nxt = S_FETCH;
      S_DONE:  state_nxt = S_IDLE;
      S_CLEAR: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    beat_r.vld <= 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      vis_r <= '0;
      pend_r <= 1'b0;
      sp_r <= '0;
      beat_r <= '0;
      for (int i = 0; i < MAX_VERTICES; i++) cnt_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: if (start) begin
          req_r <= req_type;
          a_r <= vertex_a[VW-1:0];
          b_r <= vertex_b[VW-1:0];
          nlim_r <= nact;
          edge_phase_r <= 1'b0;
          pend_r <= 1'b0;
          if (req_type == REQ_EDGE) begin
            if (!(a_ok && b_ok) ||
                ({1'b0, cnt_r[vertex_a[VW-1:0]]} +
                 ((vertex_a == vertex_b) ? (DW+1)'(2) : (DW+1)'(1)) > (DW+1)'(MAX_DEGREE)) ||
                ({1'b0, cnt_r[vertex_b[VW-1:0]]} + (DW+1)'(1) > (DW+1)'(MAX_DEGREE))) begin
              beat_r <= '{1'b1, 5'd0, ST_REJECT, 1'b1};
              state_r <= S_IDLE;
            end
          end else if ((req_type == REQ_BFS || req_type == REQ_DFS) && a_ok) begin
            vis_r <= '0;
            vis_r[vertex_a[VW-1:0]] <= 1'b1;
            head_r <= '0;
            tail_r <= PW'(1);
            q_r[0] <= vertex_a[VW-1:0];
            sv_r[0] <= vertex_a[VW-1:0];
            si_r[0] <= '0;
            sp_r <= PW'(1);
            if (req_type == REQ_DFS) begin
              pend_r <= 1'b1;
              pend_v_r <= vertex_a[VW-1:0];
            end
          end else begin
            beat_r <= '{1'b1, 5'd0, ST_REJECT, 1'b1};
          end
        end
        S_EDGE: begin
          if (!edge_phase_r) cnt_r[a_r] <= cnt_r[a_r] + DW'(1);
          else begin
            cnt_r[b_r] <= cnt_r[b_r] + DW'(1);
            beat_r <= '{1'b1, 5'd0, ST_STORED, 1'b1};
          end
          edge_phase_r <= 1'b1;
        end
        S_POP: begin
          // Pick the next vertex to scan; a held visit beat goes out when the
          // next is known, so the final one can carry last.
          if (req_r == REQ_BFS) begin
            if (head_r < tail_r) begin
              if (pend_r) beat_r <= '{1'b1, 5'(pend_v_r), ST_VISIT, 1'b0};
              pend_r <= 1'b1;
              pend_v_r <= q_r[head_r[VW-1:0]];
              top_r <= q_r[head_r[VW-1:0]];
              tcnt_r <= cnt_r[q_r[head_r[VW-1:0]]];
              idx_r <= '0;
              head_r <= head_r + PW'(1);
            end else begin
              beat_r <= '{1'b1, 5'(pend_v_r), ST_VISIT, 1'b1};
              pend_r <= 1'b0;
              state_r <= S_IDLE;
            end
          end else begin
            if (sp_r != '0) begin
              top_r <= sv_r[sp_r[VW-1:0] - VW'(1)];
              idx_r <= si_r[sp_r[VW-1:0] - VW'(1)];
              tcnt_r <= cnt_r[sv_r[sp_r[VW-1:0] - VW'(1)]];
            end else begin
              beat_r <= '{1'b1, 5'(pend_v_r), ST_VISIT, 1'b1};
              pend_r <= 1'b0;
              state_r <= S_IDLE;
            end
          end
        end
        S_FETCH: begin
          // Memory read of entry idx is in flight; DFS pops when exhausted.
          if (!(idx_r < tcnt_r) && req_r == REQ_DFS) sp_r <= sp_r - PW'(1);
        end
        S_SCAN: begin
          idx_r <= idx_r + DW'(1);
          if (req_r == REQ_DFS) begin
            si_r[sp_r[VW-1:0] - VW'(1)] <= idx_r + DW'(1);
            if (emit_nb) begin
              if (pend_r) beat_r <= '{1'b1, 5'(pend_v_r), ST_VISIT, 1'b0};
              pend_r <= 1'b1;
              pend_v_r <= rdata;
              vis_r[rdata] <= 1'b1;
              sv_r[sp_r[VW-1:0]] <= rdata;
              si_r[sp_r[VW-1:0]] <= '0;
              sp_r <= sp_r + PW'(1);
              state_r <= S_POP;
            end
          end else if (emit_nb) begin
            vis_r[rdata] <= 1'b1;
            q_r[tail_r[VW-1:0]] <= rdata;
            tail_r <= tail_r + PW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  `GBT_ASSERT_IMP(a_beat_idle, clk, rst_n, beat_r.vld && beat_r.status != ST_VISIT, beat_r.last, "non-visit beat without last")
  `GBT_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy && req_type == REQ_BFS && a_ok, busy, "walk not started")
  `GBT_ASSERT_IMP(a_sp_rng, clk, rst_n, busy, sp_r <= PW'(MAX_VERTICES), "stack overflow")

endmodule

// ----- hdl/graph_bfs_dfs_traversal_unit.sv -----
// Add-edge: the strobe is registered at the accepting edge when rejected, and after both S_EDGE writes when stored.
// Walk: each neighbour entry scanned passes S_FETCH then S_SCAN and each vertex S_POP, all through the one
// memory read port (depth-first reloads the parent in S_POP after each child); busy stays high until the last beat.
// One item at a time; the receiver cannot stall, each result lasts one cycle.
// Synchronous active-low reset clears counts, visited map and num_vertices to 32.
module graph_bfs_dfs_traversal_unit import gbt_pkg::*; #(
  parameter int MAX_DEGREE   = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_req_type,
  input  logic [4:0] in_vertex_a,
  input  logic [4:0] in_vertex_b,
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata,
  output logic       out_valid,
  output logic [4:0] out_visited_vertex,
  output logic [1:0] out_status,
  output logic       out_last_of_run
);

  logic [5:0] nv_r;
  beat_t beat;

  always_ff @(posedge clk) begin
    if (!rst_n) nv_r <= 6'd32;
    else if (cfg_we) nv_r <= cfg_wdata;
  end

  gbt_seq #(.MAX_DEGREE(MAX_DEGREE)) u_seq (
    .clk(clk), .rst_n(rst_n), .start(start), .req_type(in_req_type),
    .vertex_a(in_vertex_a), .vertex_b(in_vertex_b), .num_vertices(nv_r),
    .busy(busy), .beat(beat)
  );

  assign out_valid = beat.vld;
  assign out_visited_vertex = beat.vtx;
  assign out_status = beat.status;
  assign out_last_of_run = beat.last;

endmodule

// ----- test/testbench.sv -----
module testbench;
  import gbt_pkg::*;

  localparam int NV = 32;
  localparam int ND = 8;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic [1:0] req;
    logic [4:0] a;
    logic [4:0] b;
  } req_beat_t;

  typedef struct packed {
    logic [4:0] vtx;
    logic [1:0] status;
    logic       last;
  } res_beat_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [1:0] in_req_type = '0;
  logic [4:0] in_vertex_a = '0;
  logic [4:0] in_vertex_b = '0;
  logic cfg_we = 0;
  logic [5:0] cfg_wdata = '0;
  logic out_valid;
  logic [4:0] out_visited_vertex;
  logic [1:0] out_status;
  logic out_last_of_run;

  graph_bfs_dfs_traversal_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_vertex_a(in_vertex_a), .in_vertex_b(in_vertex_b),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_visited_vertex(out_visited_vertex),
    .out_status(out_status), .out_last_of_run(out_last_of_run)
  );

  // predictor state
  logic [5:0] nv_reg;
  logic [4:0] adj [NV*ND];
  int unsigned deg [NV];
  bit seen [NV];

  req_beat_t pending_q[$];
  res_beat_t visit_q[$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 0;
  bit cfg_req = 0;
  logic [5:0] cfg_val;

  initial forever #5 clk = ~clk;

  task automatic report(input string what, input res_beat_t got, input res_beat_t exp);
    $display("mismatch %s: got v=%0d s=%0d l=%0d exp v=%0d s=%0d l=%0d", what,
             got.vtx, got.status, got.last, exp.vtx, exp.status, exp.last);
    errors++;
  endtask

  function automatic void push_res(logic [4:0] v, logic [1:0] s, logic l);
    res_beat_t r;
    r.vtx = v; r.status = s; r.last = l;
    visit_q.insert(visit_q.size(), r);
  endfunction

  function automatic void queue_req(req_beat_t t);
    pending_q.insert(pending_q.size(), t);
  endfunction

  task automatic predict_walk(input req_beat_t it);
    int unsigned n, head, tail, sp, top, idx, nb;
    int unsigned wq[NV];
    int unsigned sv[NV];
    int unsigned si[NV];
    n = (nv_reg > NV) ? NV : nv_reg;
    if (it.req == REQ_EDGE) begin
      if (it.a >= n || it.b >= n || deg[it.a] + ((it.a == it.b) ? 2 : 1) > ND ||
          deg[it.b] + 1 > ND) begin
        push_res(0, ST_REJECT, 1);
      end else begin
        adj[it.a*ND + deg[it.a]] = it.b; deg[it.a]++;
        adj[it.b*ND + deg[it.b]] = it.a; deg[it.b]++;
        push_res(0, ST_STORED, 1);
      end
      return;
    end
    if (it.req == 2'd3 || it.a >= n) begin
      push_res(0, ST_REJECT, 1);
      return;
    end
    foreach (seen[i]) seen[i] = 0;
    if (it.req == REQ_BFS) begin
      head = 0; tail = 0;
      wq[tail++] = it.a; seen[it.a] = 1;
      while (head < tail) begin
        top = wq[head++];
        push_res(5'(top), ST_VISIT, 0);
        for (int i = 0; i < deg[top] && i < ND; i++) begin
          nb = adj[top*ND + i];
          if (nb < n && !seen[nb] && tail < NV) begin
            seen[nb] = 1; wq[tail++] = nb;
          end
        end
      end
    end else begin
      sp = 0;
      seen[it.a] = 1; push_res(it.a, ST_VISIT, 0);
      sv[0] = it.a; si[0] = 0; sp = 1;
      while (sp > 0) begin
        top = sv[sp-1]; idx = si[sp-1];
        if (idx < deg[top] && idx < ND) begin
          nb = adj[top*ND + idx];
          si[sp-1] = idx + 1;
          if (nb < n && !seen[nb] && sp < NV) begin
            seen[nb] = 1; push_res(5'(nb), ST_VISIT, 0);
            sv[sp] = nb; si[sp] = 0; sp++;
          end
        end else begin
          sp--;
        end
      end
    end
    visit_q[$].last = 1;
  endtask

  // driver: one beat at a time, idle gaps per phase
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_req) begin
        cfg_we <= 1; cfg_wdata <= cfg_val; nv_reg <= cfg_val; cfg_req <= 0;
      end else begin
        cfg_we <= 0;
        if (start && !busy) begin
          predict_walk({in_req_type, in_vertex_a, in_vertex_b});
          if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
            {in_req_type, in_vertex_a, in_vertex_b} <= pending_q.pop_front();
          end else begin
            start <= 0;
          end
        end else if (!start && pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          start <= 1;
          {in_req_type, in_vertex_a, in_vertex_b} <= pending_q.pop_front();
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_beat_t got, exp;
    cycles++;
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
    if (rst_n && out_valid) begin
      got.vtx = out_visited_vertex; got.status = out_status; got.last = out_last_of_run;
      if (visit_q.size() == 0) begin
        report("unexpected beat", got, got);
      end else begin
        exp = visit_q.pop_front();
        if (got !== exp) report("field", got, exp);
      end
    end
  end

  function automatic req_beat_t mk(logic [1:0] r, logic [4:0] a, logic [4:0] b);
    req_beat_t t;
    t.req = r; t.a = a; t.b = b;
    return t;
  endfunction

  task automatic drain();
    while (pending_q.size() > 0 || start || busy || visit_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_count(logic [5:0] v);
    @(posedge clk);
    cfg_val = v; cfg_req = 1;
    while (cfg_req) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic random_phase(int count, int n, int idle);
    int r;
    send_idle = idle;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 55) queue_req(mk(REQ_EDGE, 5'($urandom_range(n-1)), 5'($urandom_range(n-1))));
      else if (r < 75) queue_req(mk(REQ_BFS, 5'($urandom_range(n-1)), 5'($urandom)));
      else if (r < 92) queue_req(mk(REQ_DFS, 5'($urandom_range(n-1)), 5'($urandom)));
      else queue_req(mk(2'($urandom), 5'($urandom), 5'($urandom)));
    end
    drain();
  endtask

  initial begin
    nv_reg = 6'd32;
    foreach (deg[i]) deg[i] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed
    queue_req(mk(REQ_BFS, 0, 0));
    queue_req(mk(REQ_EDGE, 0, 31));
    queue_req(mk(REQ_EDGE, 0, 1));
    queue_req(mk(REQ_EDGE, 1, 2));
    queue_req(mk(REQ_EDGE, 2, 2));
    queue_req(mk(REQ_EDGE, 31, 30));
    queue_req(mk(REQ_BFS, 0, 31));
    queue_req(mk(REQ_DFS, 31, 0));
    queue_req(mk(2'd3, 5, 5));
    for (int i = 3; i < 11; i++) queue_req(mk(REQ_EDGE, 5, 5'(i)));
    queue_req(mk(REQ_EDGE, 5, 12));
    queue_req(mk(REQ_EDGE, 2, 2));
    queue_req(mk(REQ_DFS, 5, 0));
    drain();
    set_count(6'd63);
    queue_req(mk(REQ_BFS, 31, 0));
    drain();
    set_count(6'd0);
    queue_req(mk(REQ_EDGE, 0, 0));
    queue_req(mk(REQ_BFS, 0, 0));
    queue_req(mk(REQ_DFS, 0, 0));
    drain();
    set_count(6'd4);
    queue_req(mk(REQ_BFS, 0, 0));
    queue_req(mk(REQ_DFS, 5, 0));
    queue_req(mk(REQ_DFS, 1, 0));
    drain();
    set_count(6'd32);
    random_phase(50, 32, 0);
    set_count(6'd12);
    random_phase(50, 16, 70);
    set_count(6'd1);
    random_phase(15, 2, 10);
    set_count(6'd32);
    random_phase(70, 32, $urandom_range(1) ? 0 : 40);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
